// ===== rtl/sau_pkg.sv =====
// Shared types and constants for the sensor average alert block.
`default_nettype none

package sau_pkg;

   localparam int READING_W   = 8;
   localparam int ADDR_W      = 64;
   localparam int INDEX_W     = 4;
   localparam int CNT_W       = 7;    // holds a peer count up to 127
   localparam int QUEUE_DEPTH = 2;

   localparam logic [READING_W-1:0] THR_RESET = 8'd19;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_SCAN,
      FE_WIN,
      FE_MUL,
      FE_PUSH
   } sau_fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_WAIT,
      BE_EMIT
   } sau_be_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] lo;
   } sau_peer_type;

   typedef struct packed {
      logic               en;
      logic [CNT_W-1:0]   addr;
      sau_peer_type       data;
   } sau_wr_type;

   // One alert burst: send to the first peer_count table entries.
   typedef struct packed {
      logic               valid;
      logic [CNT_W-1:0]   peer_count;
   } sau_job_type;

endpackage

`default_nettype wire

// ===== rtl/sau_req_if.sv =====
// Request channel: one reading and the sender's address.
`default_nettype none

interface sau_req_if;
   logic                             valid;
   logic                             ready;
   logic [sau_pkg::READING_W-1:0]    reading;
   logic [sau_pkg::ADDR_W-1:0]       peer_addr_hi;
   logic [sau_pkg::ADDR_W-1:0]       peer_addr_lo;

   modport source (output valid, output reading, output peer_addr_hi, output peer_addr_lo,
                   input ready);
   modport sink   (input valid, input reading, input peer_addr_hi, input peer_addr_lo,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sau_rsp_if.sv =====
// Response channel: one alert per recorded peer.
`default_nettype none

interface sau_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sau_pkg::ADDR_W-1:0]       alert_addr_hi;
   logic [sau_pkg::ADDR_W-1:0]       alert_addr_lo;
   logic [sau_pkg::INDEX_W-1:0]      peer_index;
   logic                             last_alert;

   modport source (output valid, output alert_addr_hi, output alert_addr_lo,
                   output peer_index, output last_alert, input ready);
   modport sink   (input valid, input alert_addr_hi, input alert_addr_lo,
                   input peer_index, input last_alert, output ready);
endinterface

`default_nettype wire

// ===== rtl/sau_csr_if.sv =====
// Control register write channel for the alert threshold.
`default_nettype none

interface sau_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sau_pkg::READING_W-1:0]    threshold;

   modport source (output valid, output threshold, input ready);
   modport sink   (input valid, input threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/sensor_average_alert_fanout.sv =====
// Top level of the sensor average alert block.
//
// Channels: req_chan takes one request (reading plus 128-bit sender address),
// rsp_chan returns alerts, csr_chan writes the 8-bit alert threshold (reset 19).
// Each request records its sender in the peer table (deduplicated, while not
// full), stores the reading in the circular window, and, when the average of
// the nonzero window entries exceeds the threshold, queues one alert burst:
// one response per recorded peer in table order, the final one marked last.
//
// Flow: the front end holds a request while it compares the peer table,
// one entry per cycle over the read port of the peer store, then updates
// the window, forms the threshold product and pushes any alert job; the
// compare stops early on a match and is skipped once the table is full.
// The back end reads each alert's peer from its own read port, passing a
// wait state before each alert, and holds while the receiver stalls. A
// two-entry job queue lets the front end take the next request while alerts
// are still going out.
// Reset clears the window, slot pointer, peer count, queue and response
// register; no clearing pass is needed. When the receiver stalls, the
// response register holds, then the job queue fills, then req ready drops.
`default_nettype none

module sensor_average_alert_fanout #(
   parameter int WINDOW_DEPTH = 10,
   parameter int PEER_DEPTH   = 10
) (
   input  wire          clock,
   input  wire          reset,
   sau_req_if.sink      req_chan,
   sau_rsp_if.source    rsp_chan,
   sau_csr_if.sink      csr_chan
);
   import sau_pkg::*;

   sau_wr_type          peer_wr;
   logic [CNT_W-1:0]    fe_rd_addr;
   sau_peer_type        fe_rd_data;
   logic [CNT_W-1:0]    be_rd_addr;
   sau_peer_type        be_rd_data;
   sau_job_type         job_push;
   logic                job_push_ready;
   sau_job_type         job_pop;
   logic                job_pop_ready;

   // peer table: front end appends and compares, back end reads for alerts
   sau_peer_mem #(
      .DEPTH (PEER_DEPTH)
   ) u_peer_mem (
      .clock     (clock),
      .wr        (peer_wr),
      .rd_a_addr (fe_rd_addr),
      .rd_a_data (fe_rd_data),
      .rd_b_addr (be_rd_addr),
      .rd_b_data (be_rd_data)
   );

   sau_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .PEER_DEPTH   (PEER_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_chan     (csr_chan),
      .peer_wr      (peer_wr),
      .peer_rd_addr (fe_rd_addr),
      .peer_rd_data (fe_rd_data),
      .job_push     (job_push),
      .job_ready    (job_push_ready)
   );

   // alert jobs carry the peer count seen by their request; table entries
   // below that count are never rewritten, so the back end may lag freely
   sau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_ready (job_push_ready),
      .pop        (job_pop),
      .pop_ready  (job_pop_ready)
   );

   sau_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_pop      (job_pop),
      .job_ready    (job_pop_ready),
      .peer_rd_addr (be_rd_addr),
      .peer_rd_data (be_rd_data),
      .rsp_chan     (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/sau_peer_mem.sv =====
// Peer address store: one write port, two registered read ports.
`default_nettype none

module sau_peer_mem #(
   parameter int DEPTH = 10
) (
   input  wire                          clock,
   input  sau_pkg::sau_wr_type          wr,
   input  wire [sau_pkg::CNT_W-1:0]     rd_a_addr,
   output sau_pkg::sau_peer_type        rd_a_data,
   input  wire [sau_pkg::CNT_W-1:0]     rd_b_addr,
   output sau_pkg::sau_peer_type        rd_b_data
);
   import sau_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   sau_peer_type mem [DEPTH];
   sau_peer_type rd_a_ff;
   sau_peer_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_a_ff <= mem[rd_a_addr[AW-1:0]];
      rd_b_ff <= mem[rd_b_addr[AW-1:0]];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/sau_front.sv =====
// Front end: takes requests, records peers, updates window sums, decides alerts.
`default_nettype none

module sau_front #(
   parameter int WINDOW_DEPTH = 10,
   parameter int PEER_DEPTH   = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   sau_req_if.sink                      req_chan,
   sau_csr_if.sink                      csr_chan,
   output sau_pkg::sau_wr_type          peer_wr,
   output logic [sau_pkg::CNT_W-1:0]    peer_rd_addr,
   input  sau_pkg::sau_peer_type        peer_rd_data,
   output sau_pkg::sau_job_type         job_push,
   input  wire                          job_ready
);
   import sau_pkg::*;

   localparam int PCW = $clog2(PEER_DEPTH + 1);
   localparam int WAW = $clog2(WINDOW_DEPTH);
   localparam int WCW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW  = READING_W + WCW;

   sau_fe_state_type        state_ff, state_in;

   logic [READING_W-1:0]    thr_ff, thr_in;
   logic [READING_W-1:0]    reading_ff, reading_in;
   sau_peer_type            addr_ff, addr_in;

   logic [PCW-1:0]          peer_cnt_ff, peer_cnt_in;
   logic [PCW-1:0]          scan_ff, scan_in;
   logic                    cmp_vld_ff, cmp_vld_in;

   logic [READING_W-1:0]    win_mem [WINDOW_DEPTH];
   logic [READING_W-1:0]    win_rd_ff;
   logic [WINDOW_DEPTH-1:0] win_vld_ff, win_vld_in;
   logic [WAW-1:0]          slot_ff, slot_in;
   logic [SW-1:0]           sum_ff, sum_in;
   logic [WCW-1:0]          cnt_ff, cnt_in;
   logic [SW-1:0]           prod_ff, prod_in;

   logic                    accept;
   logic                    full;
   logic                    issue;
   logic                    hit;
   logic                    scan_done;
   logic                    record;
   logic [READING_W-1:0]    old_val;
   logic                    alert;

   assign accept    = req_chan.valid && req_chan.ready;
   assign full      = (peer_cnt_ff == PCW'(PEER_DEPTH));
   assign issue     = (scan_ff != peer_cnt_ff);
   assign hit       = cmp_vld_ff && (peer_rd_data == addr_ff);
   assign scan_done = hit || full || (!issue && !cmp_vld_ff);
   assign record    = (state_ff == FE_SCAN) && scan_done && !hit && !full;
   assign old_val   = win_vld_ff[slot_ff] ? win_rd_ff : '0;
   assign alert     = (cnt_ff != '0) && (sum_ff > prod_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE: begin
            if (accept) state_in = FE_SCAN;
         end
         FE_SCAN: begin
            if (scan_done) state_in = FE_WIN;
         end
         FE_WIN:  state_in = FE_MUL;
         FE_MUL:  state_in = FE_PUSH;
         FE_PUSH: begin
            if (!job_push.valid || job_ready) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_chan.ready      = (state_ff == FE_IDLE);
      csr_chan.ready      = 1'b1;

      thr_in      = (csr_chan.valid) ? csr_chan.threshold : thr_ff;
      reading_in  = reading_ff;
      addr_in     = addr_ff;
      peer_cnt_in = peer_cnt_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      win_vld_in  = win_vld_ff;
      slot_in     = slot_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;

      peer_wr.en   = record;
      peer_wr.addr = CNT_W'(peer_cnt_ff);
      peer_wr.data = addr_ff;
      peer_rd_addr = CNT_W'(scan_ff);

      job_push.valid      = (state_ff == FE_PUSH) && alert && (peer_cnt_ff != '0);
      job_push.peer_count = CNT_W'(peer_cnt_ff);

      case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               reading_in = req_chan.reading;
               addr_in.hi = req_chan.peer_addr_hi;
               addr_in.lo = req_chan.peer_addr_lo;
               scan_in    = '0;
            end
         end
         FE_SCAN: begin
            if (record) peer_cnt_in = peer_cnt_ff + 1'b1;
            if (!scan_done && issue) begin
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
         end
         FE_WIN: begin
            sum_in = sum_ff - SW'(old_val) + SW'(reading_ff);
            cnt_in = cnt_ff - WCW'(old_val != '0) + WCW'(reading_ff != '0);
            win_vld_in[slot_ff] = 1'b1;
            slot_in = (slot_ff == WAW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         end
         FE_MUL: begin
            prod_in = SW'(thr_ff) * SW'(cnt_ff);
         end
         FE_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FE_IDLE;
         thr_ff      <= THR_RESET;
         peer_cnt_ff <= '0;
         scan_ff     <= '0;
         cmp_vld_ff  <= 1'b0;
         win_vld_ff  <= '0;
         slot_ff     <= '0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         thr_ff      <= thr_in;
         peer_cnt_ff <= peer_cnt_in;
         scan_ff     <= scan_in;
         cmp_vld_ff  <= cmp_vld_in;
         win_vld_ff  <= win_vld_in;
         slot_ff     <= slot_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      reading_ff <= reading_in;
      addr_ff    <= addr_in;
      prod_ff    <= prod_in;
   end

   // window store: old entry is always read at the current slot
   always_ff @(posedge clock) begin
      if (state_ff == FE_WIN) begin
         win_mem[slot_ff] <= reading_ff;
      end
      win_rd_ff <= win_mem[slot_ff];
   end

endmodule

`default_nettype wire

// ===== rtl/sau_queue.sv =====
// Short job queue between the front and back ends.
`default_nettype none

module sau_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  sau_pkg::sau_job_type  push,
   output logic                  push_ready,
   output sau_pkg::sau_job_type  pop,
   input  wire                   pop_ready
);
   import sau_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready     = (fill_ff != QCW'(QUEUE_DEPTH));
   assign pop.valid      = (fill_ff != '0);
   assign pop.peer_count = slot_ff[rd_ptr_ff];
   assign do_push        = push.valid && push_ready;
   assign do_pop         = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + QCW'(do_push) - QCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.peer_count;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sau_back.sv =====
// Back end: walks the peer table and sends one alert per recorded peer.
`default_nettype none

module sau_back (
   input  wire                          clock,
   input  wire                          reset,
   input  sau_pkg::sau_job_type         job_pop,
   output logic                         job_ready,
   output logic [sau_pkg::CNT_W-1:0]    peer_rd_addr,
   input  sau_pkg::sau_peer_type        peer_rd_data,
   sau_rsp_if.source                    rsp_chan
);
   import sau_pkg::*;

   sau_be_state_type     state_ff, state_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   sau_peer_type         rsp_addr_ff, rsp_addr_in;
   logic [INDEX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 can_load;
   logic                 is_last;

   assign can_load = !rsp_vld_ff || rsp_chan.ready;
   assign is_last  = ((k_ff + 1'b1) == total_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: begin
            if (job_pop.valid) state_in = BE_WAIT;
         end
         BE_WAIT: state_in = BE_EMIT;
         BE_EMIT: begin
            if (can_load) state_in = is_last ? BE_IDLE : BE_WAIT;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_ready    = (state_ff == BE_IDLE);
      peer_rd_addr = k_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         BE_IDLE: begin
            if (job_pop.valid) begin
               total_in = job_pop.peer_count;
               k_in     = '0;
            end
         end
         BE_WAIT: begin
         end
         BE_EMIT: begin
            if (can_load) begin
               rsp_vld_in  = 1'b1;
               rsp_addr_in = peer_rd_data;
               rsp_idx_in  = INDEX_W'(k_ff);
               rsp_last_in = is_last;
               k_in        = k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_chan.valid         = rsp_vld_ff;
      rsp_chan.alert_addr_hi = rsp_addr_ff.hi;
      rsp_chan.alert_addr_lo = rsp_addr_ff.lo;
      rsp_chan.peer_index    = rsp_idx_ff;
      rsp_chan.last_alert    = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BE_IDLE;
         rsp_vld_ff <= 1'b0;
         total_ff   <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         total_ff   <= total_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sau_checker.sv =====
// Port-level checks on the alert block, bound to the top level.
`default_nettype none

module sau_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [sau_pkg::ADDR_W-1:0]      rsp_addr_hi,
   input wire [sau_pkg::ADDR_W-1:0]      rsp_addr_lo,
   input wire [sau_pkg::INDEX_W-1:0]     rsp_peer_index,
   input wire                            rsp_last_alert
);
   import sau_pkg::*;

   logic [INDEX_W-1:0] exp_idx_ff, exp_idx_in;
   logic               rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_take) begin
         exp_idx_in = rsp_last_alert ? '0 : exp_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   // a stalled alert holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr_hi)
         && $stable(rsp_addr_lo) && $stable(rsp_peer_index) && $stable(rsp_last_alert))
      else $error("alert changed while stalled");

   // alerts of one burst walk the table from entry zero
   a_idx_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_peer_index == exp_idx_ff)
      else $error("alert peer index out of sequence");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("alert valid right after reset");

endmodule

bind sensor_average_alert_fanout sau_checker u_sau_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_addr_hi    (rsp_chan.alert_addr_hi),
   .rsp_addr_lo    (rsp_chan.alert_addr_lo),
   .rsp_peer_index (rsp_chan.peer_index),
   .rsp_last_alert (rsp_chan.last_alert)
);

`default_nettype wire

// ===== dv/tb_sensor_average_alert_fanout.sv =====
// Self-checking testbench for sensor_average_alert_fanout: predicted alert bursts vs. DUT.
`default_nettype none

module tb_sensor_average_alert_fanout;
   timeunit 1ns;
   timeprecision 1ps;

   import sau_pkg::*;

   // Sizes match the DUT parameters below.
   localparam int WIN_SLOTS    = 10;
   localparam int PEER_SLOTS   = 10;
   // Quiet time after the last alert before a threshold write or the end:
   // the front end may still be holding a request that raised no alert.
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 80;
   localparam int PRINT_LIMIT   = 100;

   // One alert as it should leave the response channel.
   typedef struct packed {
      logic [ADDR_W-1:0]  hi;
      logic [ADDR_W-1:0]  lo;
      logic [INDEX_W-1:0] index;
      logic               last;
   } alert_type;

   // Tracks window, peer table and threshold; expands each accepted request
   // into the alert burst it must cause and checks alerts in order.
   class fanout_checker;
      logic [READING_W-1:0] threshold;
      logic [READING_W-1:0] window [WIN_SLOTS];
      int unsigned          slot;
      sau_peer_type         peers [PEER_SLOTS];
      int unsigned          peer_count;
      alert_type            alerts_due [$];
      int unsigned          mismatch_count;

      function new();
         threshold      = THR_RESET;
         slot           = 0;
         peer_count     = 0;
         mismatch_count = 0;
         foreach (window[k]) window[k] = '0;
      endfunction

      task report(input string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns mismatch: %s", $time, msg);
      endtask

      function void set_threshold(input logic [READING_W-1:0] value);
         threshold = value;
      endfunction

      function void note_reading(input logic [READING_W-1:0] value, input sau_peer_type sender);
         int unsigned sum;
         int unsigned count;
         int unsigned k;
         bit          known;
         alert_type   a;
         // Sender goes into the table only while there is room; full table
         // skips the duplicate compare entirely.
         if (peer_count < PEER_SLOTS) begin
            known = 1'b0;
            for (k = 0; k < peer_count; k++)
               if (peers[k] == sender) known = 1'b1;
            if (!known) begin
               peers[peer_count] = sender;
               peer_count++;
            end
         end
         // Zero readings are stored but do not count toward the average.
         window[slot] = value;
         slot = (slot == WIN_SLOTS - 1) ? 0 : slot + 1;
         sum   = 0;
         count = 0;
         for (k = 0; k < WIN_SLOTS; k++)
            if (window[k] != '0) begin
               sum += window[k];
               count++;
            end
         // Exact compare of the average: sum > threshold * count.
         if (count != 0 && sum > threshold * count)
            for (k = 0; k < peer_count; k++) begin
               a.hi    = peers[k].hi;
               a.lo    = peers[k].lo;
               a.index = INDEX_W'(k);
               a.last  = (k + 1 == peer_count);
               alerts_due.push_back(a);
            end
      endfunction

      task check_alert(input alert_type got);
         alert_type want;
         if (alerts_due.size() == 0) begin
            report($sformatf("alert with none expected: %h_%h index %0d last %0b",
                             got.hi, got.lo, got.index, got.last));
            return;
         end
         want = alerts_due.pop_front();
         if (got.hi !== want.hi)
            report($sformatf("alert_addr_hi %h, expected %h", got.hi, want.hi));
         if (got.lo !== want.lo)
            report($sformatf("alert_addr_lo %h, expected %h", got.lo, want.lo));
         if (got.index !== want.index)
            report($sformatf("peer_index %0d, expected %0d", got.index, want.index));
         if (got.last !== want.last)
            report($sformatf("last_alert %0b, expected %0b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   sau_req_if req_if ();
   sau_rsp_if rsp_if ();
   sau_csr_if csr_if ();

   fanout_checker checker_h;
   int            burst_left = 0;

   sensor_average_alert_fanout #(
      .WINDOW_DEPTH (WIN_SLOTS),
      .PEER_DEPTH   (PEER_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Random 128-bit sender address.
   function automatic sau_peer_type random_peer();
      sau_peer_type p;
      p.hi = {$urandom, $urandom};
      p.lo = {$urandom, $urandom};
      return p;
   endfunction

   // Sends one request. The sender runs in bursts: when a burst is used up,
   // valid drops for a random gap (sometimes none) and a new burst starts.
   // Valid stays high across back-to-back requests inside a burst.
   task automatic send_reading(input logic [READING_W-1:0] value, input sau_peer_type sender);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_if.valid        <= 1'b1;
      req_if.reading      <= value;
      req_if.peer_addr_hi <= sender.hi;
      req_if.peer_addr_lo <= sender.lo;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      checker_h.note_reading(value, sender);
      burst_left--;
   endtask

   task automatic req_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
   endtask

   // Block is idle once every predicted alert is out and the front end has
   // had time to finish a request that raised none.
   task automatic wait_idle();
      int waited;
      waited = 0;
      while (checker_h.alerts_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [READING_W-1:0] value);
      csr_if.valid     <= 1'b1;
      csr_if.threshold <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      checker_h.set_threshold(value);
   endtask

   // Random requests at the current threshold. Readings mix zeros, full
   // scale, values right at the threshold edge and occasional runs of zeros
   // long enough to empty the window. Senders mix recorded peers, extreme
   // addresses and fresh ones (ignored once the table is full).
   task automatic run_phase(input int n_items);
      int                   i;
      int                   quiet_left;
      int                   pick;
      logic [READING_W-1:0] value;
      sau_peer_type         sender;
      quiet_left = 0;
      for (i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (quiet_left > 0) begin
            value = '0;
            quiet_left--;
         end else if (pick < 3) begin
            value = '0;
            quiet_left = $urandom_range(9, 11);
         end else if (pick < 18)
            value = '0;
         else if (pick < 28)
            value = '1;
         else if (pick < 43) begin
            value = checker_h.threshold;
            if (value != '1 && $urandom_range(0, 1) == 1) value = value + 1'b1;
         end else
            value = READING_W'($urandom_range(1, 255));

         pick = $urandom_range(0, 99);
         if (pick < 30 && checker_h.peer_count != 0)
            sender = checker_h.peers[$urandom_range(0, checker_h.peer_count - 1)];
         else if (pick < 40) begin
            sender.hi = ($urandom_range(0, 1) == 1) ? '1 : '0;
            sender.lo = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end else
            sender = random_peer();
         send_reading(value, sender);
      end
   endtask

   // Receiver: each stretch picks a stall pattern — none, light, heavy, or
   // a fixed one-in-six accept rhythm.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int tick;
      rsp_if.ready <= 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_if.ready <= ($urandom_range(0, 2) == 0);
               end
               default: begin
                  rsp_if.ready <= (tick % 6 == 0);
               end
            endcase
         end
      end
   end

   // Alert monitor: values sampled at the edge, before this edge's updates.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         checker_h.check_alert('{hi: rsp_if.alert_addr_hi, lo: rsp_if.alert_addr_lo,
                                 index: rsp_if.peer_index, last: rsp_if.last_alert});
   end

   initial begin : main_sequence
      sau_peer_type a0;
      sau_peer_type a1;
      sau_peer_type hi_only;
      sau_peer_type lo_only;
      sau_peer_type near_a1;
      int           n;

      checker_h = new();
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.reading      <= '0;
      req_if.peer_addr_hi <= '0;
      req_if.peer_addr_lo <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.threshold    <= '0;

      a0      = '{hi: '0, lo: '0};
      a1      = '{hi: '1, lo: '1};
      hi_only = '{hi: '1, lo: '0};
      lo_only = '{hi: '0, lo: '1};
      near_a1 = '{hi: '1, lo: 64'h1};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset threshold of 19.
      send_reading(8'd255, a0);       // first peer, single alert
      send_reading(8'd0, a0);         // duplicate sender, zero reading not averaged
      send_reading(8'd1, a1);         // second peer, burst of two
      send_reading(8'd19, hi_only);   // halves compared separately
      send_reading(8'd0, lo_only);
      send_reading(8'd0, hi_only);    // exact duplicate
      send_reading(8'd0, near_a1);    // upper half matches, lower differs
      // Zeros until the window is empty; senders fill the table and then
      // overflow it, so the last ones must be dropped.
      for (n = 0; n < 7; n++)
         send_reading(8'd0, random_peer());
      send_reading(8'd19, a0);        // average equals threshold: no alert
      send_reading(8'd20, random_peer()); // just above: full ten-peer burst
      send_reading(8'd255, a1);

      // Random part: threshold swept across extremes and random settings.
      req_idle();
      wait_idle();
      write_threshold(8'd0);
      run_phase(PHASE_ITEMS);
      req_idle();
      wait_idle();
      write_threshold(8'd255);
      run_phase(PHASE_ITEMS);
      req_idle();
      wait_idle();
      write_threshold(READING_W'($urandom_range(1, 254)));
      run_phase(PHASE_ITEMS);
      req_idle();
      wait_idle();
      write_threshold(8'd128);
      run_phase(PHASE_ITEMS);
      req_idle();
      wait_idle();
      write_threshold(READING_W'($urandom_range(1, 254)));
      run_phase(PHASE_ITEMS);
      req_idle();
      wait_idle();
      write_threshold(8'd1);
      run_phase(PHASE_ITEMS);

      req_idle();
      wait_idle();
      if (checker_h.alerts_due.size() != 0)
         checker_h.report($sformatf("%0d alerts never arrived", checker_h.alerts_due.size()));

      if (checker_h.mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : run_limit
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/sau_pkg.sv
rtl/sau_req_if.sv
rtl/sau_rsp_if.sv
rtl/sau_csr_if.sv
rtl/sau_peer_mem.sv
rtl/sau_front.sv
rtl/sau_queue.sv
rtl/sau_back.sv
rtl/sensor_average_alert_fanout.sv
rtl/sau_checker.sv
dv/tb_sensor_average_alert_fanout.sv
